// ===== rtl/rsas_pkg.sv =====
// Shared constants, codes and types for the rotated sorted array search block.
package rsas_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = 10;
  localparam int LEN_W  = 11;
  localparam int DATA_W = 32;
  // Signed search bounds: hi may drop to -1 and lo may reach DEPTH.
  localparam int BND_W  = 12;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Byte address of the array_length register.
  localparam logic [2:0] REG_ARRAY_LENGTH = 3'd0;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROBE  = 6'b000010,
    S_EVAL   = 6'b000100,
    S_HIRD   = 6'b001000,
    S_HIEVAL = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

// ===== rtl/rotated_sorted_array_search_top.sv =====
// A write item is stored at its accepting edge and gives no result. A search raises out_tvalid
// once its probes (at most 11) end in a hit or a miss; each probe reads the middle and low
// entries, and some probes also read the top entry.
// Throughput: one item at a time; in_tready returns with out_tvalid, and a finished search
// waits while the previous result is still held.
// Synchronous active-low reset clears the FSM, output valid and array_length, not the store.
module rotated_sorted_array_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [9:0] index, [41:10] value, [47:42] zero
  input  logic        in_tuser,    // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [9:0] position, [15:10] zero
  output logic        out_tuser,   // [0] found
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [rsas_pkg::LEN_W-1:0]        array_length_r, array_length_nxt;
  rsas_pkg::mem_req_t                mem_req;
  logic signed [rsas_pkg::DATA_W-1:0] rdata_a;
  logic signed [rsas_pkg::DATA_W-1:0] rdata_b;
  logic [rsas_pkg::ADDR_W-1:0]       pos;

  assign cfg_pready = 1'b1;

  always_comb begin
    array_length_nxt = array_length_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr == rsas_pkg::REG_ARRAY_LENGTH) begin
      array_length_nxt = cfg_pwdata[rsas_pkg::LEN_W-1:0];
    end
    cfg_prdata = (cfg_paddr == rsas_pkg::REG_ARRAY_LENGTH) ?
                 {{(32-rsas_pkg::LEN_W){1'b0}}, array_length_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else begin
      array_length_r <= array_length_nxt;
    end
  end

  rsas_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rsas_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_len   (array_length_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_index  (in_tdata[9:0]),
    .in_value  ($signed(in_tdata[41:10])),
    .mem_req   (mem_req),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (out_tuser),
    .out_pos   (pos)
  );

  assign out_tdata = {6'd0, pos};

endmodule

// ===== rtl/rsas_mem.sv =====
// Element store: one write port and two registered read ports.
module rsas_mem (
  input  logic                                clk,
  input  rsas_pkg::mem_req_t                  req,
  output logic signed [rsas_pkg::DATA_W-1:0]  rdata_a,
  output logic signed [rsas_pkg::DATA_W-1:0]  rdata_b
);

  logic [rsas_pkg::DATA_W-1:0] mem [rsas_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

// ===== rtl/rsas_search.sv =====
// Search sequencer: accepts items, drives the element store and holds the result.
module rsas_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rsas_pkg::LEN_W-1:0]          cfg_len,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [rsas_pkg::ADDR_W-1:0]         in_index,
  input  logic signed [rsas_pkg::DATA_W-1:0]  in_value,
  output rsas_pkg::mem_req_t                  mem_req,
  input  logic signed [rsas_pkg::DATA_W-1:0]  rdata_a,
  input  logic signed [rsas_pkg::DATA_W-1:0]  rdata_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [rsas_pkg::ADDR_W-1:0]         out_pos
);

  rsas_pkg::state_t state_r, state_nxt;

  logic signed [rsas_pkg::BND_W-1:0]  lo_r, lo_nxt;
  logic signed [rsas_pkg::BND_W-1:0]  hi_r, hi_nxt;
  logic signed [rsas_pkg::BND_W-1:0]  mid_r, mid_nxt;
  logic signed [rsas_pkg::DATA_W-1:0] tgt_r, tgt_nxt;
  logic                               found_r, found_nxt;
  logic [rsas_pkg::ADDR_W-1:0]        pos_r, pos_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [rsas_pkg::ADDR_W-1:0]        out_pos_r, out_pos_nxt;

  logic [rsas_pkg::LEN_W-1:0]         len;
  logic signed [rsas_pkg::BND_W-1:0]  span;
  logic signed [rsas_pkg::BND_W-1:0]  mid_c;
  logic                               accept;

  assign in_ready  = (state_r == rsas_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_pos   = out_pos_r;

  always_comb begin
    len = (cfg_len > rsas_pkg::LEN_W'(rsas_pkg::DEPTH)) ?
          rsas_pkg::LEN_W'(rsas_pkg::DEPTH) : cfg_len;
    span  = hi_r - lo_r;
    mid_c = lo_r + (span >>> 1);
  end

  always_comb begin
    mem_req.we      = accept && (in_op == rsas_pkg::OP_WRITE);
    mem_req.waddr   = in_index;
    mem_req.wdata   = in_value;
    mem_req.raddr_a = (state_r == rsas_pkg::S_HIRD) ? hi_r[rsas_pkg::ADDR_W-1:0]
                                                    : mid_c[rsas_pkg::ADDR_W-1:0];
    mem_req.raddr_b = lo_r[rsas_pkg::ADDR_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    tgt_nxt       = tgt_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;

    unique case (state_r)
      rsas_pkg::S_IDLE: begin
        if (accept && (in_op == rsas_pkg::OP_SEARCH)) begin
          tgt_nxt   = in_value;
          lo_nxt    = '0;
          hi_nxt    = $signed({1'b0, len}) - rsas_pkg::BND_W'(1);
          state_nxt = rsas_pkg::S_PROBE;
        end
      end
      rsas_pkg::S_PROBE: begin
        if (lo_r > hi_r) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = rsas_pkg::S_DONE;
        end else begin
          mid_nxt   = mid_c;
          state_nxt = rsas_pkg::S_EVAL;
        end
      end
      rsas_pkg::S_EVAL: begin
        // rdata_a holds the middle entry, rdata_b the low entry.
        state_nxt = rsas_pkg::S_PROBE;
        if (rdata_a == tgt_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r[rsas_pkg::ADDR_W-1:0];
          state_nxt = rsas_pkg::S_DONE;
        end else if (rdata_b <= rdata_a) begin
          if (rdata_a < tgt_r) begin
            lo_nxt = mid_r + rsas_pkg::BND_W'(1);
          end else if (rdata_b <= tgt_r) begin
            hi_nxt = mid_r - rsas_pkg::BND_W'(1);
          end else begin
            lo_nxt = mid_r + rsas_pkg::BND_W'(1);
          end
        end else if (tgt_r < rdata_a) begin
          hi_nxt = mid_r - rsas_pkg::BND_W'(1);
        end else begin
          // Right half is sorted; its top entry decides.
          state_nxt = rsas_pkg::S_HIRD;
        end
      end
      rsas_pkg::S_HIRD: begin
        state_nxt = rsas_pkg::S_HIEVAL;
      end
      rsas_pkg::S_HIEVAL: begin
        if (tgt_r <= rdata_a) begin
          lo_nxt = mid_r + rsas_pkg::BND_W'(1);
        end else begin
          hi_nxt = mid_r - rsas_pkg::BND_W'(1);
        end
        state_nxt = rsas_pkg::S_PROBE;
      end
      rsas_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = pos_r;
          state_nxt     = rsas_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rsas_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsas_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    tgt_r       <= tgt_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

endmodule

// ===== rtl/rsas_checker.sv =====
// Port-level checks for the rotated sorted array search block, bound to the top level.
module rsas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("not-found result with nonzero position");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port stalled");

endmodule

bind rotated_sorted_array_search_top rsas_checker u_rsas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
